>>> rtl/xgcd_pkg.sv
// Package: widths and types shared by the extended gcd unit.
package xgcd_pkg;

    localparam int WIDTH = 64;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int FW    = 64;

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPD,
        ST_RED,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        word_t rem;
        logic  dvd_bit;
        word_t dvs;
        word_t acc_s;
        word_t acc_t;
        word_t sc;
        word_t tc;
        cnt_t  shamt;
    } step_in_t;

    typedef struct packed {
        word_t rem;
        logic  ge;
        word_t acc_s;
        word_t acc_t;
    } step_out_t;

endpackage

>>> rtl/xgcd_in_if.sv
// Interface: input channel carrying value and modulus.
interface xgcd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [63:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink (input valid, input value, input modulus, output ready);
endinterface

>>> rtl/xgcd_out_if.sv
// Interface: result channel carrying coefficients, gcd and inverse.
interface xgcd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] coef_value;
    logic [63:0] coef_modulus;
    logic [63:0] gcd_out;
    logic [63:0] inverse;
    logic        invertible;

    modport source (output valid, output coef_value, output coef_modulus,
                    output gcd_out, output inverse, output invertible, input ready);
    modport sink (input valid, input coef_value, input coef_modulus,
                  input gcd_out, input inverse, input invertible, output ready);
endinterface

>>> rtl/xgcd_step.sv
// Shared unit: one restoring division bit plus coefficient update.
module xgcd_step
    import xgcd_pkg::*;
(
    input  step_in_t  si,
    output step_out_t so
);

    logic [WIDTH:0] cand;
    logic [WIDTH:0] diff;

    always_comb
    begin
        cand     = {si.rem, si.dvd_bit};
        diff     = cand - {1'b0, si.dvs};
        so.ge    = ~diff[WIDTH];
        so.rem   = so.ge ? diff[WIDTH-1:0] : cand[WIDTH-1:0];
        so.acc_s = so.ge ? si.acc_s - (si.sc << si.shamt) : si.acc_s;
        so.acc_t = so.ge ? si.acc_t - (si.tc << si.shamt) : si.acc_t;
    end

endmodule

>>> rtl/extended_gcd_modular_inverse_unit.sv
// Each Euclid iteration runs a bit-serial divide; an invertible input then gets a final reduction.
// Both use the bit-serial divide step, one quotient bit per cycle.
// One item at a time; input ready only when idle.
// Reset returns the sequencer to idle with no result pending.
module extended_gcd_modular_inverse_unit
    import xgcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    xgcd_in_if.sink    in_ch,
    xgcd_out_if.source out_ch
);

    state_t state_reg, state_next;
    word_t  rp_reg, rp_next, rc_reg, rc_next;
    word_t  sp_reg, sp_next, sc_reg, sc_next;
    word_t  tp_reg, tp_next, tc_reg, tc_next;
    word_t  p_reg, p_next;
    word_t  dvd_reg, dvd_next, dvs_reg, dvs_next;
    word_t  rem_reg, rem_next;
    word_t  ns_reg, ns_next, nt_reg, nt_next;
    cnt_t   cnt_reg, cnt_next;
    logic   neg_reg, neg_next;
    logic   ok_reg, ok_next;
    logic [FW-1:0] os_reg, os_next, ot_reg, ot_next;
    logic [FW-1:0] og_reg, og_next, oi_reg, oi_next;
    logic   oinv_reg, oinv_next;
    step_in_t  si;
    step_out_t so;

    xgcd_step u_step (.si(si), .so(so));

    always_comb
    begin
        si.rem     = rem_reg;
        si.dvd_bit = dvd_reg[cnt_reg];
        si.dvs     = dvs_reg;
        si.acc_s   = ns_reg;
        si.acc_t   = nt_reg;
        si.sc      = sc_reg;
        si.tc      = tc_reg;
        si.shamt   = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg   <= rp_next;
        rc_reg   <= rc_next;
        sp_reg   <= sp_next;
        sc_reg   <= sc_next;
        tp_reg   <= tp_next;
        tc_reg   <= tc_next;
        p_reg    <= p_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        ns_reg   <= ns_next;
        nt_reg   <= nt_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        ok_reg   <= ok_next;
        os_reg   <= os_next;
        ot_reg   <= ot_next;
        og_reg   <= og_next;
        oi_reg   <= oi_next;
        oinv_reg <= oinv_next;
    end

    always_comb
    begin
        state_next = state_reg;
        rp_next    = rp_reg;
        rc_next    = rc_reg;
        sp_next    = sp_reg;
        sc_next    = sc_reg;
        tp_next    = tp_reg;
        tc_next    = tc_reg;
        p_next     = p_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        ns_next    = ns_reg;
        nt_next    = nt_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        ok_next    = ok_reg;
        os_next    = os_reg;
        ot_next    = ot_reg;
        og_next    = og_reg;
        oi_next    = oi_reg;
        oinv_next  = oinv_reg;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    rp_next    = in_ch.value[WIDTH-1:0];
                    rc_next    = in_ch.modulus[WIDTH-1:0];
                    p_next     = in_ch.modulus[WIDTH-1:0];
                    sp_next    = word_t'(1);
                    sc_next    = '0;
                    tp_next    = '0;
                    tc_next    = word_t'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                rem_next = '0;
                cnt_next = cnt_t'(WIDTH-1);
                if (rc_reg != '0)
                begin
                    dvd_next   = rp_reg;
                    dvs_next   = rc_reg;
                    ns_next    = sp_reg;
                    nt_next    = tp_reg;
                    state_next = ST_DIV;
                end
                else
                begin
                    ok_next  = (p_reg != '0) && (rp_reg == word_t'(1));
                    neg_next = sp_reg[WIDTH-1];
                    dvd_next = sp_reg[WIDTH-1] ? word_t'(-sp_reg) : sp_reg;
                    dvs_next = p_reg;
                    if ((p_reg != '0) && (rp_reg == word_t'(1)))
                    begin
                        state_next = ST_RED;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = so.rem;
                ns_next  = so.acc_s;
                nt_next  = so.acc_t;
                cnt_next = cnt_reg - cnt_t'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                rp_next    = rc_reg;
                rc_next    = rem_reg;
                sp_next    = sc_reg;
                sc_next    = ns_reg;
                tp_next    = tc_reg;
                tc_next    = nt_reg;
                state_next = ST_CHECK;
            end
            ST_RED:
            begin
                rem_next = so.rem;
                cnt_next = cnt_reg - cnt_t'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                os_next   = FW'(signed'(sp_reg));
                ot_next   = FW'(signed'(tp_reg));
                og_next   = FW'(rp_reg);
                oinv_next = ok_reg;
                if (!ok_reg)
                begin
                    oi_next = '0;
                end
                else if (neg_reg && (rem_reg != '0))
                begin
                    oi_next = FW'(p_reg - rem_reg);
                end
                else
                begin
                    oi_next = FW'(rem_reg);
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.coef_value   = os_reg;
    assign out_ch.coef_modulus = ot_reg;
    assign out_ch.gcd_out      = og_reg;
    assign out_ch.inverse      = oi_reg;
    assign out_ch.invertible   = oinv_reg;

endmodule

>>> dv/xgcd_tb_pkg.sv
`timescale 1ns / 100ps
// Testbench package: input and result item types for the extended gcd unit.
package xgcd_tb_pkg;

    typedef struct {
        logic [63:0] value;
        logic [63:0] modulus;
    } xgcd_item_t;

    typedef struct {
        logic [63:0] coef_value;
        logic [63:0] coef_modulus;
        logic [63:0] gcd_out;
        logic [63:0] inverse;
        logic        invertible;
    } xgcd_result_t;

endpackage

>>> dv/tb_extended_gcd_modular_inverse_unit.sv
`timescale 1ns / 100ps
// Testbench top: drives value/modulus items, predicts xgcd results and checks them.
module tb_extended_gcd_modular_inverse_unit
    import xgcd_pkg::*, xgcd_tb_pkg::*;
;

    localparam longint LIMIT = 64'd12_000_000;

    logic clk;
    logic rst_n;

    xgcd_in_if  in_ch();
    xgcd_out_if out_ch();

    extended_gcd_modular_inverse_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    xgcd_item_t   pending_items[$];
    xgcd_result_t expected_results[$];
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_sender;
    int           fail_count = 0;
    longint       cycle_count = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic xgcd_result_t compute_xgcd(logic [63:0] value_in,
                                                  logic [63:0] modulus_in);
        logic [WIDTH-1:0] mask;
        logic [63:0]      a;
        logic [63:0]      p;
        logic [63:0]      rp, rc, sp, sc, tp, tc, q, nr, ns, nt, rem;
        xgcd_result_t     res;
        mask = '1;
        a  = value_in & 64'(mask);
        p  = modulus_in & 64'(mask);
        rp = a;
        rc = p;
        sp = 64'd1;
        sc = 64'd0;
        tp = 64'd0;
        tc = 64'd1;
        while (rc != 0)
        begin
            q  = rp / rc;
            nr = rp - q * rc;
            ns = sp - q * sc;
            nt = tp - q * tc;
            rp = rc;
            rc = nr;
            sp = sc;
            sc = ns;
            tp = tc;
            tc = nt;
        end
        res.coef_value   = sp;
        res.coef_modulus = tp;
        res.gcd_out      = rp;
        res.invertible   = (p != 0) && (rp == 64'd1);
        res.inverse      = 64'd0;
        if (res.invertible)
        begin
            if (!sp[63])
                res.inverse = sp % p;
            else
            begin
                rem = (64'd0 - sp) % p;
                res.inverse = (rem == 0) ? 64'd0 : p - rem;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_operand();
        int          kind;
        logic [63:0] v;
        kind = $urandom_range(0, 9);
        v = rand64();
        case (kind)
            0: v = v & 64'hFF;
            1: v = v & 64'hFFFF;
            2: v = v & 64'hFFFF_FFFF;
            3: v = v | 64'h8000_0000_0000_0000;
            4: v = 64'd1 << $urandom_range(0, 63);
            5: v = 64'($urandom_range(0, 3));
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_item(logic [63:0] value_in, logic [63:0] modulus_in);
        xgcd_item_t it;
        it.value   = value_in;
        it.modulus = modulus_in;
        pending_items.push_back(it);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.value   <= '0;
            in_ch.modulus <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(compute_xgcd(in_ch.value, in_ch.modulus));
            if (pending_items.size() != 0 && !hold_sender
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_ch.valid   <= 1'b1;
                in_ch.value   <= pending_items[0].value;
                in_ch.modulus <= pending_items[0].modulus;
                void'(pending_items.pop_front());
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    xgcd_result_t e;
                    e = expected_results.pop_front();
                    if (out_ch.coef_value !== e.coef_value)
                    begin
                        $error("coef_value exp %h got %h", e.coef_value, out_ch.coef_value);
                        fail_count++;
                    end
                    if (out_ch.coef_modulus !== e.coef_modulus)
                    begin
                        $error("coef_modulus exp %h got %h", e.coef_modulus,
                               out_ch.coef_modulus);
                        fail_count++;
                    end
                    if (out_ch.gcd_out !== e.gcd_out)
                    begin
                        $error("gcd_out exp %h got %h", e.gcd_out, out_ch.gcd_out);
                        fail_count++;
                    end
                    if (out_ch.inverse !== e.inverse)
                    begin
                        $error("inverse exp %h got %h", e.inverse, out_ch.inverse);
                        fail_count++;
                    end
                    if (out_ch.invertible !== e.invertible)
                    begin
                        $error("invertible exp %b got %b", e.invertible, out_ch.invertible);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("tb_extended_gcd_modular_inverse_unit: FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 55;
        hold_sender   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zeros, ones, extremes, negative coefficients, upper bits
        add_item(64'd0, 64'd0);
        add_item(64'd5, 64'd0);
        add_item(64'd0, 64'd7);
        add_item(64'd3, 64'd1);
        add_item(64'd3, 64'd7);
        add_item(64'd2, 64'd7);
        add_item(64'd6, 64'd9);
        add_item(64'd1, 64'd1);
        add_item('1, '1);
        add_item('1, 64'd0);
        add_item(64'd0, '1);
        add_item('1, 64'hFFFF_FFFF_FFFF_FFFE);
        add_item(64'hFFFF_FFFF_FFFF_FFFE, '1);
        add_item(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        add_item(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        add_item(64'd12200160415121876738, 64'd7540113804746346429);
        add_item(64'd7540113804746346429, 64'd12200160415121876738);
        add_item(64'd3, 64'h8000_0000_0000_0000);
        add_item(64'd10, 64'd4);
        add_item(64'd14, 64'd21);
        add_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        add_item(64'd1, 64'd2);
        wait_drained();

        // sender is held off for a random wait once every result has come
        hold_sender = 1'b1;
        repeat ($urandom_range(10, 80)) @(posedge clk);
        hold_sender = 1'b0;

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 55 : 0;
            recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 10 : 0;
            for (int i = 0; i < 90; i++)
                add_item(rand_operand(), rand_operand());
            wait_drained();
        end

        repeat (6400) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb_extended_gcd_modular_inverse_unit: PASS");
        else
            $display("tb_extended_gcd_modular_inverse_unit: FAIL");
        $finish;
    end

endmodule
